/* hw/rtl/dedm_pkg.sv */
// ============================================================================
// dedm_pkg: shared types and constants
// Widths, register indexes and the stage-to-stage record of the echo meter.
// ============================================================================
package dedm_pkg;

    localparam int TRIG_W  = 8;
    localparam int COUNT_W = 19;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 13;
    localparam int PROD_W  = COUNT_W + SCALE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_TRIGGER_LENGTH = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_DISTANCE_SCALE = 2'd2;

    localparam logic [TRIG_W-1:0]  TRIGGER_LENGTH_RST = 8'd20;
    localparam logic [COUNT_W-1:0] TIMEOUT_LIMIT_RST  = 19'd327680;
    localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 16'd1126;

    // per-tick result before scaling
    typedef struct packed {
        logic               trig;
        logic               busy;
        logic               done;
        logic               timed;
        logic [COUNT_W-1:0] left_ticks;
        logic [COUNT_W-1:0] right_ticks;
    } dedm_meas_t;

endpackage

/* hw/rtl/dual_echo_distance_meter.sv */
// ============================================================================
// dual_echo_distance_meter: two-channel ultrasonic echo timer
// Each input transfer is one timer tick carrying a start request and the two
// sampled echo levels; each tick yields exactly one output transfer. Ticks
// stream at one per clock while m_tready does not stall: the sequencer registers
// its update in the first stage, the counts are scaled to centimetres in the
// second, and the result register feeds m_tdata. An accepted tick is held in
// the sequencer's record register and then in the result register; a low
// m_tready can hold it in either. Distances are floor(ticks * scale /
// 65536) saturated to 8191; a channel that does not fall before the timeout
// reads 0 and timed_out is set. Registers (APB, 32-bit): 0x0 trigger_length,
// 0x4 timeout_limit, 0x8 distance_scale; write them only while idle.
// ============================================================================
module dual_echo_distance_meter
    import dedm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_r, [2] echo_l
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                   // [15:3] left_distance, [28:16] right_distance,
                                   // [29] timed_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TRIG_W-1:0]  trigger_length_reg;
    logic [COUNT_W-1:0] timeout_limit_reg;
    logic [SCALE_W-1:0] distance_scale_reg;
    logic               cfg_write;
    logic               meas_valid;
    logic               meas_ready;
    dedm_meas_t         meas;

    // ---- register file -----------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_length_reg <= TRIGGER_LENGTH_RST;
            timeout_limit_reg  <= TIMEOUT_LIMIT_RST;
            distance_scale_reg <= DISTANCE_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TRIGGER_LENGTH: trigger_length_reg <= pwdata[TRIG_W-1:0];
                REG_TIMEOUT_LIMIT:  timeout_limit_reg  <= pwdata[COUNT_W-1:0];
                REG_DISTANCE_SCALE: distance_scale_reg <= pwdata[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TRIGGER_LENGTH: prdata = 32'(trigger_length_reg);
            REG_TIMEOUT_LIMIT:  prdata = 32'(timeout_limit_reg);
            REG_DISTANCE_SCALE: prdata = 32'(distance_scale_reg);
            default:            prdata = '0;
        endcase
    end

    // ---- stage 1: sequencer, one tick per accepted transfer ------------------
    dedm_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .start_req      (s_tdata[0]),
        .echo_r         (s_tdata[1]),
        .echo_l         (s_tdata[2]),
        .trigger_length (trigger_length_reg),
        .timeout_limit  (timeout_limit_reg),
        .out_valid      (meas_valid),
        .out_ready      (meas_ready),
        .meas           (meas)
    );

    // ---- stage 2: scale to centimetres, result register ----------------------
    dedm_scale u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (meas_valid),
        .in_ready       (meas_ready),
        .meas           (meas),
        .distance_scale (distance_scale_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // trigger is only driven while a measurement is under way
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("trigger high while not busy");

    // the finishing tick leaves the block idle and never triggers
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (!m_tdata[1] && !m_tdata[0]))
        else $error("done tick shows busy or trigger");

    // an empty first stage always takes the next tick
    a_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !meas_valid |-> s_tready)
        else $error("input stalled with empty sequencer stage");
`endif

endmodule

/* hw/rtl/dedm_ctrl.sv */
// ============================================================================
// dedm_ctrl: measurement sequencer
// Trigger, wait for rise and timing of both echoes; one tick per transfer.
// ============================================================================
module dedm_ctrl
    import dedm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_req,
    input  logic               echo_r,
    input  logic               echo_l,
    input  logic [TRIG_W-1:0]  trigger_length,
    input  logic [COUNT_W-1:0] timeout_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output dedm_meas_t         meas
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIGGER,
        PH_WAIT_RISE,
        PH_MEASURE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               left_fin_reg, left_fin_next;
    logic               right_fin_reg, right_fin_next;
    logic [COUNT_W-1:0] left_ticks_reg, left_ticks_next;
    logic [COUNT_W-1:0] right_ticks_reg, right_ticks_next;
    logic               timeout_reg, timeout_next;
    logic               valid_reg;
    dedm_meas_t         meas_reg, meas_next;
    logic [COUNT_W-1:0] count_inc;
    logic               accept;
    logic               trig;
    logic               done;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign meas      = meas_reg;
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        left_fin_next    = left_fin_reg;
        right_fin_next   = right_fin_reg;
        left_ticks_next  = left_ticks_reg;
        right_ticks_next = right_ticks_reg;
        timeout_next     = timeout_reg;
        trig             = 1'b0;
        done             = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next       = PH_TRIGGER;
                    count_next       = COUNT_W'(1);
                    left_ticks_next  = '0;
                    right_ticks_next = '0;
                    timeout_next     = 1'b0;
                    left_fin_next    = 1'b0;
                    right_fin_next   = 1'b0;
                    trig             = 1'b1;
                end
            end
            PH_TRIGGER:
            begin
                // a zero length still gives one trigger tick
                if (count_reg >= COUNT_W'(trigger_length))
                begin
                    phase_next = PH_WAIT_RISE;
                end
                else
                begin
                    count_next = count_inc;
                    trig       = 1'b1;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo_r)
                begin
                    phase_next     = PH_MEASURE;
                    count_next     = '0;
                    left_fin_next  = 1'b0;
                    right_fin_next = 1'b0;
                end
            end
            PH_MEASURE:
            begin
                count_next = count_inc;
                if (!right_fin_reg && !echo_r)
                begin
                    right_fin_next   = 1'b1;
                    right_ticks_next = count_inc;
                end
                if (!left_fin_reg && !echo_l)
                begin
                    left_fin_next   = 1'b1;
                    left_ticks_next = count_inc;
                end
                if (right_fin_next && left_fin_next)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else if (count_inc >= timeout_limit)
                begin
                    if (!right_fin_next)
                        right_ticks_next = '0;
                    if (!left_fin_next)
                        left_ticks_next = '0;
                    timeout_next = 1'b1;
                    phase_next   = PH_IDLE;
                    done         = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        meas_next.trig        = trig;
        meas_next.busy        = (phase_next != PH_IDLE);
        meas_next.done        = done;
        meas_next.timed       = timeout_next;
        meas_next.left_ticks  = left_ticks_next;
        meas_next.right_ticks = right_ticks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            left_fin_reg    <= 1'b0;
            right_fin_reg   <= 1'b0;
            left_ticks_reg  <= '0;
            right_ticks_reg <= '0;
            timeout_reg     <= 1'b0;
            valid_reg       <= 1'b0;
            meas_reg        <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (accept)
            begin
                phase_reg       <= phase_next;
                count_reg       <= count_next;
                left_fin_reg    <= left_fin_next;
                right_fin_reg   <= right_fin_next;
                left_ticks_reg  <= left_ticks_next;
                right_ticks_reg <= right_ticks_next;
                timeout_reg     <= timeout_next;
                meas_reg        <= meas_next;
            end
        end
    end

endmodule

/* hw/rtl/dedm_scale.sv */
// ============================================================================
// dedm_scale: ticks to centimetres
// Q0.16 multiply of both captured counts, saturation, and the result register.
// ============================================================================
module dedm_scale
    import dedm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dedm_meas_t         meas,
    input  logic [SCALE_W-1:0] distance_scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_data
);

    logic [PROD_W-1:0]  left_prod, right_prod;
    logic [COUNT_W-1:0] left_int, right_int;
    logic [DIST_W-1:0]  left_cm, right_cm;
    logic [31:0]        data_reg, data_next;
    logic               valid_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        left_prod  = PROD_W'(meas.left_ticks) * PROD_W'(distance_scale);
        right_prod = PROD_W'(meas.right_ticks) * PROD_W'(distance_scale);
        left_int   = left_prod[PROD_W-1:16];
        right_int  = right_prod[PROD_W-1:16];
        left_cm    = (|left_int[COUNT_W-1:DIST_W]) ? DIST_MAX : left_int[DIST_W-1:0];
        right_cm   = (|right_int[COUNT_W-1:DIST_W]) ? DIST_MAX : right_int[DIST_W-1:0];
        data_next  = {2'b00, meas.timed, right_cm, left_cm,
                      meas.done, meas.busy, meas.trig};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* sim/dedm_echo_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// dedm_echo_checker: tick predictor and result scoreboard for the echo meter
// Mirrors register writes from the APB port and predicts one result per
// accepted input tick. Each output transfer is compared field by field with the
// oldest prediction.
// ============================================================================
module dedm_echo_checker
    import dedm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_r, [2] echo_l
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                   // [15:3] left_distance, [28:16] right_distance,
                                   // [29] timed_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending_ticks
);

    typedef enum logic [1:0] {
        METER_IDLE,
        METER_TRIGGER,
        METER_WAIT_RISE,
        METER_MEASURE
    } meter_phase_e;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] left_cm;
        logic [DIST_W-1:0] right_cm;
        logic              timed;
    } tick_result_t;

    // register mirror
    logic [TRIG_W-1:0]  trig_len;
    logic [COUNT_W-1:0] timeout_lim;
    logic [SCALE_W-1:0] cm_scale;

    // meter state
    meter_phase_e       phase;
    logic [COUNT_W-1:0] tick_cnt;
    logic [COUNT_W-1:0] left_cnt;
    logic [COUNT_W-1:0] right_cnt;
    logic               left_seen;
    logic               right_seen;
    logic               timeout_hit;

    tick_result_t tick_results_q[$];

    function automatic logic [DIST_W-1:0] ticks_to_cm(input logic [COUNT_W-1:0] ticks);
        logic [PROD_W-1:0] prod;
        prod = (PROD_W'(ticks) * PROD_W'(cm_scale)) >> 16;
        return (prod > PROD_W'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
    endfunction

    function automatic tick_result_t step_meter(input logic start, input logic r_echo,
                                                input logic l_echo);
        tick_result_t res;
        logic         trig;
        logic         done;
        trig = 1'b0;
        done = 1'b0;
        case (phase)
            METER_IDLE:
                if (start)
                begin
                    phase       = METER_TRIGGER;
                    tick_cnt    = COUNT_W'(1);
                    left_cnt    = '0;
                    right_cnt   = '0;
                    timeout_hit = 1'b0;
                    left_seen   = 1'b0;
                    right_seen  = 1'b0;
                    trig        = 1'b1;
                end
            METER_TRIGGER:
                // a zero length ends here too, so it acts as one tick
                if (tick_cnt >= COUNT_W'(trig_len))
                    phase = METER_WAIT_RISE;
                else
                begin
                    tick_cnt = tick_cnt + 1'b1;
                    trig     = 1'b1;
                end
            METER_WAIT_RISE:
                if (r_echo)
                begin
                    phase      = METER_MEASURE;
                    tick_cnt   = '0;
                    left_seen  = 1'b0;
                    right_seen = 1'b0;
                end
            default:
            begin
                if (tick_cnt != COUNT_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                if (!right_seen && !r_echo)
                begin
                    right_seen = 1'b1;
                    right_cnt  = tick_cnt;
                end
                if (!left_seen && !l_echo)
                begin
                    left_seen = 1'b1;
                    left_cnt  = tick_cnt;
                end
                // both edges seen wins over a timeout on the same tick
                if (right_seen && left_seen)
                begin
                    phase = METER_IDLE;
                    done  = 1'b1;
                end
                else if (tick_cnt >= timeout_lim)
                begin
                    if (!right_seen)
                        right_cnt = '0;
                    if (!left_seen)
                        left_cnt = '0;
                    timeout_hit = 1'b1;
                    phase       = METER_IDLE;
                    done        = 1'b1;
                end
            end
        endcase
        res.trig     = trig;
        res.busy     = (phase != METER_IDLE);
        res.done     = done;
        res.left_cm  = ticks_to_cm(left_cnt);
        res.right_cm = ticks_to_cm(right_cnt);
        res.timed    = timeout_hit;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            trig_len    = TRIGGER_LENGTH_RST;
            timeout_lim = TIMEOUT_LIMIT_RST;
            cm_scale    = DISTANCE_SCALE_RST;
            phase       = METER_IDLE;
            tick_cnt    = '0;
            left_cnt    = '0;
            right_cnt   = '0;
            left_seen   = 1'b0;
            right_seen  = 1'b0;
            timeout_hit = 1'b0;
            tick_results_q.delete();
        end
        else
        begin
            // results are matched before this edge's tick is predicted
            if (m_tvalid && m_tready)
            begin
                if (tick_results_q.size() == 0)
                    report_mismatch($sformatf("unexpected result transfer 0x%08h", m_tdata));
                else
                begin
                    want = tick_results_q.pop_front();
                    check_field("trigger_level", m_tdata[0], want.trig);
                    check_field("busy_res", m_tdata[1], want.busy);
                    check_field("done_res", m_tdata[2], want.done);
                    check_field("left_distance", m_tdata[15:3], want.left_cm);
                    check_field("right_distance", m_tdata[28:16], want.right_cm);
                    check_field("timed_out", m_tdata[29], want.timed);
                end
            end
            if (s_tvalid && s_tready)
                tick_results_q.push_back(step_meter(s_tdata[0], s_tdata[1], s_tdata[2]));
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_TRIGGER_LENGTH: trig_len    = pwdata[TRIG_W-1:0];
                    REG_TIMEOUT_LIMIT:  timeout_lim = pwdata[COUNT_W-1:0];
                    REG_DISTANCE_SCALE: cm_scale    = pwdata[SCALE_W-1:0];
                    default: ;
                endcase
        end
        pending_ticks = tick_results_q.size();
    end

endmodule

/* sim/tb_dual_echo_distance_meter.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_dual_echo_distance_meter: stimulus and verdict for the echo meter
// Streams timer ticks built as whole measurements (trigger, wait for rise,
// echo pulses of random width, timeouts) plus idle noise, reprograms the
// registers between measurements, and throttles both stream sides at random.
// A checker beside the block predicts and compares every result.
// ============================================================================
module tb_dual_echo_distance_meter
    import dedm_pkg::*;
();

    localparam int TOTAL_TICKS = 850;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] start_req, [1] echo_r, [2] echo_l
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] trigger_level, [1] busy_res, [2] done_res,
                            // [15:3] left_distance, [28:16] right_distance,
                            // [29] timed_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending_ticks;

    // stimulus bookkeeping
    bit                 quiet;        // no idling on either side once set
    int                 ticks_sent;
    logic [TRIG_W-1:0]  cur_trig;     // register values as last programmed
    logic [COUNT_W-1:0] cur_timeout;

    dual_echo_distance_meter dut (.*);

    dedm_echo_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .pending_ticks (pending_ticks)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Result side: random stall bursts until the quiet tail of the run.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(9, 0) == 0)
                    stall_left = $urandom_range(15, 1);
            end
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    // One tick transfer. Called at a falling edge, returns at a falling edge
    // with tvalid still high so back-to-back ticks keep the stream full.
    task automatic send_tick(input logic start, input logic r_echo, input logic l_echo);
        if (!quiet && $urandom_range(9, 0) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, l_echo, r_echo, start};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic idle_noise(input int n);
        repeat (n) send_tick(1'b0, rand_bit(), rand_bit());
    endtask

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the rising edge inside the access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Reprogram only with the meter idle and the pipeline drained: every
    // predicted result back from the two-stage pipeline, then the register writes.
    task automatic configure(input logic [TRIG_W-1:0] trig, input logic [COUNT_W-1:0] tmo,
                             input logic [SCALE_W-1:0] scale);
        s_tvalid <= 1'b0;
        while (pending_ticks != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_TRIGGER_LENGTH, 32'(trig));
        write_reg(REG_TIMEOUT_LIMIT, 32'(tmo));
        write_reg(REG_DISTANCE_SCALE, 32'(scale));
        cur_trig    = trig;
        cur_timeout = tmo;
    endtask

    // One well-formed measurement. left_fall / right_fall are the counting
    // ticks at which each echo is first low; the run ends at the later one or
    // at the timeout, whichever comes first, so the meter is idle afterwards.
    // Echo levels during the trigger and after capture are don't-care and get
    // random values; stray starts while busy must be ignored.
    task automatic run_measurement(input int wait_ticks, input int left_fall,
                                   input int right_fall, input bit start_at_end);
        int trig_ticks;
        int tmo_ticks;
        int last_tick;
        trig_ticks = (cur_trig == 0) ? 1 : int'(cur_trig);
        tmo_ticks  = (cur_timeout == 0) ? 1 : int'(cur_timeout);
        last_tick  = (left_fall > right_fall) ? left_fall : right_fall;
        if (tmo_ticks < last_tick)
            last_tick = tmo_ticks;
        send_tick(1'b1, rand_bit(), rand_bit());
        repeat (trig_ticks) send_tick(rand_bit(), rand_bit(), rand_bit());
        repeat (wait_ticks) send_tick(rand_bit(), 1'b0, rand_bit());
        send_tick(rand_bit(), 1'b1, rand_bit());   // right echo rise
        for (int k = 1; k <= last_tick; k++)
            send_tick((k == last_tick) ? start_at_end : ($urandom_range(15, 0) == 0),
                      (k < right_fall) || (k > right_fall && rand_bit()),
                      (k < left_fall) || (k > left_fall && rand_bit()));
    endtask

    initial
    begin
        int meas_left;
        int sel;
        logic [TRIG_W-1:0]  new_trig;
        logic [COUNT_W-1:0] new_tmo;
        logic [SCALE_W-1:0] new_scale;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        ticks_sent  = 0;
        cur_trig    = TRIGGER_LENGTH_RST;
        cur_timeout = TIMEOUT_LIMIT_RST;
        meas_left   = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // idle ticks with every echo combination
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        // reset register values
        run_measurement(2, 3, 5, 1'b0);
        // zero trigger length and zero timeout, largest scale
        configure(8'd0, 19'd0, 16'hFFFF);
        run_measurement(0, 2, 2, 1'b0);   // both channels time out
        run_measurement(1, 1, 1, 1'b1);   // captured on the timeout tick; start on done
        run_measurement(0, 1, 3, 1'b0);   // left captured, right times out
        run_measurement(0, 3, 1, 1'b0);   // right captured, left times out
        // longest trigger and timeout
        configure(8'd255, 19'h7FFFF, 16'hFFFF);
        run_measurement(3, 40, 30, 1'b0);
        // held counts rescaled by later scale writes
        configure(8'd1, 19'h7FFFF, 16'h0000);
        idle_noise(2);
        configure(8'd1, 19'd1, 16'h8000);
        idle_noise(2);
        run_measurement(0, 1, 1, 1'b0);   // timeout of one

        // ---- random part ----
        // Mostly whole measurements in phases of a few, each phase with fresh
        // register values; idle noise in between. Both sides idle until the
        // tail of the run.
        while (ticks_sent < TOTAL_TICKS)
        begin
            if (ticks_sent >= TOTAL_TICKS - 120)
                quiet = 1'b1;
            if (meas_left == 0)
            begin
                sel = $urandom_range(11, 0);
                new_trig = (sel == 0) ? 8'd255 : (sel == 1) ? 8'd0 : (sel == 2) ? 8'd1 :
                           TRIG_W'($urandom_range(6, 1));
                sel = $urandom_range(9, 0);
                new_tmo = (sel == 0) ? 19'h7FFFF : (sel == 1) ? 19'd0 : (sel == 2) ? 19'd1 :
                          COUNT_W'($urandom_range(50, 2));
                sel = $urandom_range(9, 0);
                new_scale = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF :
                            SCALE_W'($urandom_range(65535, 0));
                configure(new_trig, new_tmo, new_scale);
                // long triggers are costly, so they get one measurement only
                meas_left = (new_trig > 8'd10) ? 1 : $urandom_range(6, 3);
            end
            if ($urandom_range(4, 0) == 0)
                idle_noise($urandom_range(6, 1));
            else
            begin
                run_measurement($urandom_range(6, 0), $urandom_range(45, 1),
                                $urandom_range(45, 1), $urandom_range(2, 0) == 0);
                meas_left--;
            end
        end

        // ---- drain and verdict ----
        s_tvalid <= 1'b0;
        quiet = 1'b1;
        while (pending_ticks != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("dual_echo_distance_meter regression: pass");
        else
            $display("dual_echo_distance_meter regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every tick hit by the
    // longest gap on both sides).
    initial
    begin
        #20_000_000;
        $display("dual_echo_distance_meter regression: fail");
        $finish;
    end

endmodule
